// File: rtl/bsb_pkg.sv
package bsb_pkg;

  // bitmap geometry
  localparam int BITS        = 1024;
  localparam int STORE_BYTES = (BITS + 7) / 8;
  localparam int WORD_BYTES  = 4;
  localparam int WORD_BITS   = WORD_BYTES * 8;
  localparam int WORDS       = (STORE_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int WADDR_W     = $clog2(WORDS);
  localparam int LANE_W      = $clog2(WORD_BYTES);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WORD_SHIFT  = BIT_W;

  // field widths
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 7;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 10;
  localparam int LEN_W   = 11;
  localparam int BYTE_OK_W = WORDS * WORD_BYTES;
  localparam int GB_W      = WADDR_W + LANE_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(BITS);
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIRST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LAST  = 3'd4;

  // queue depth between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_FILL,
    OP_COMP,
    OP_FIRST,
    OP_LAST
  } op_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

  // one classified job: word range and bit bounds
  typedef struct packed {
    op_t                 op;
    logic [WADDR_W-1:0]  waddr;
    logic [WADDR_W-1:0]  wend;
    logic [LANE_W-1:0]   lane;
    logic [BYTE_W-1:0]   value;
    logic [LEN_W-1:0]    lo;
    logic [LEN_W-1:0]    hi;
  } task_t;

endpackage

// File: rtl/bsb_front.sv
module bsb_front import bsb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               full,
  input  logic [CMD_W-1:0]   command,
  input  logic [INDEX_W-1:0] byte_index,
  input  logic [BYTE_W-1:0]  byte_value,
  input  logic [POS_W-1:0]   start_bit,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_data,
  output logic               push,
  output task_t              entry
);

  logic [LEN_W-1:0] length_reg;
  logic [LEN_W-1:0] len_used;
  logic [LEN_W-1:0] start_ext;
  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] lim_m1;
  logic [LEN_W:0]   nbytes_sum;
  logic             start_out;

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= LEN_RESET;
    end else if (cfg_we) begin
      length_reg <= cfg_data;
    end
  end

  // bounds derived from the clamped length
  always_comb begin
    len_used   = (length_reg > LEN_MAX) ? LEN_MAX : length_reg;
    start_ext  = LEN_W'(start_bit);
    len_m1     = len_used - LEN_W'(1);
    limit      = len_used - start_ext;
    lim_m1     = limit - LEN_W'(1);
    nbytes_sum = ({1'b0, len_used} + (LEN_W+1)'(7)) >> 3;
    start_out  = (start_ext >= len_used);
  end

  assign push = start && !full;

  // command decode
  always_comb begin
    entry       = '0;
    entry.op    = OP_NONE;
    entry.value = byte_value;
    entry.lane  = byte_index[LANE_W-1:0];
    unique case (command)
      CMD_WRITE: begin
        if (32'(byte_index) < STORE_BYTES) begin
          entry.op    = OP_WRITE;
          entry.waddr = WADDR_W'(byte_index >> LANE_W);
        end
      end
      CMD_FILL: begin
        entry.op   = OP_FILL;
        entry.wend = WADDR_W'(WORDS - 1);
      end
      CMD_COMP: begin
        if (len_used != '0) begin
          entry.op   = OP_COMP;
          entry.wend = len_m1[WORD_SHIFT +: WADDR_W];
          entry.hi   = nbytes_sum[LEN_W-1:0];
        end
      end
      CMD_FIRST: begin
        if (!start_out) begin
          entry.op    = OP_FIRST;
          entry.waddr = start_ext[WORD_SHIFT +: WADDR_W];
          entry.wend  = len_m1[WORD_SHIFT +: WADDR_W];
          entry.lo    = start_ext;
          entry.hi    = len_used;
        end
      end
      CMD_LAST: begin
        if (!start_out) begin
          entry.op    = OP_LAST;
          entry.waddr = lim_m1[WORD_SHIFT +: WADDR_W];
          entry.wend  = '0;
          entry.hi    = limit;
        end
      end
      default: begin
        entry.op = OP_NONE;
      end
    endcase
  end

endmodule

// File: rtl/bsb_queue.sv
module bsb_queue import bsb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t entry_in,
  input  logic  pop,
  output task_t entry_out,
  output logic  empty,
  output logic  full
);

  task_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty     = (count == '0);
  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign entry_out = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry_in;
  end

endmodule

// File: rtl/bsb_engine.sv
module bsb_engine import bsb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  task_t            q_head,
  output logic             q_pop,
  output logic             done,
  output logic             found,
  output logic [POS_W-1:0] bit_position
);

  eng_state_t state, state_next;
  task_t      cur;

  logic [WORD_BITS-1:0]  mem [WORDS];
  logic [WORD_BITS-1:0]  rdata;
  logic [BYTE_OK_W-1:0]  byte_ok;

  logic [WADDR_W-1:0]    ptr, ptr_next;
  logic [WADDR_W-1:0]    rd_addr;
  logic                  issue, issue_next;
  logic                  rd_valid, rdv_next;

  logic                  mem_we;
  logic [WORD_BYTES-1:0] mem_be;
  logic [WADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  logic                  finish;
  logic                  res_found;
  logic [POS_W-1:0]      res_pos;

  logic [WORD_BITS-1:0]  word_data;
  logic [WORD_BITS-1:0]  cand;
  logic [WORD_BYTES-1:0] inv;
  logic [BIT_W-1:0]      low_idx;
  logic [BIT_W-1:0]      high_idx;
  logic [LEN_W-1:0]      pos_ext;
  logic [GB_W-1:0]       gb;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ENG_IDLE;
      issue    <= 1'b0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      byte_ok  <= '0;
    end else begin
      state    <= state_next;
      issue    <= issue_next;
      rd_valid <= rdv_next;
      done     <= finish;
      if (mem_we) begin
        for (int k = 0; k < WORD_BYTES; k++) begin
          if (mem_be[k]) byte_ok[{mem_waddr, LANE_W'(k)}] <= 1'b1;
        end
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    ptr     <= ptr_next;
    rd_addr <= ptr;
    if (finish) begin
      found        <= res_found;
      bit_position <= res_pos;
    end
  end

  // bitmap word memory with byte enables
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int k = 0; k < WORD_BYTES; k++) begin
        if (mem_be[k]) mem[mem_waddr][k*8 +: 8] <= mem_wdata[k*8 +: 8];
      end
    end
    rdata <= mem[ptr];
  end

  // masked read word, bit candidates and complement lanes
  always_comb begin
    word_data = rdata;
    cand      = '0;
    inv       = '0;
    pos_ext   = '0;
    gb        = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (!byte_ok[{rd_addr, LANE_W'(k)}]) word_data[k*8 +: 8] = '0;
      gb     = {rd_addr, LANE_W'(k)};
      inv[k] = (LEN_W'(gb) < cur.hi);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      pos_ext = LEN_W'({rd_addr, BIT_W'(b)});
      cand[b] = word_data[b] && (pos_ext >= cur.lo) && (pos_ext < cur.hi);
    end
  end

  // lowest and highest candidate
  always_comb begin
    low_idx  = '0;
    high_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) low_idx = BIT_W'(b);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (cand[b]) high_idx = BIT_W'(b);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: if (!q_empty) state_next = ENG_RUN;
      ENG_RUN:  if (finish) state_next = ENG_IDLE;
      default:  state_next = ENG_IDLE;
    endcase
  end

  // outputs: queue pop, memory access, scan pointer and result
  always_comb begin
    q_pop      = (state == ENG_IDLE) && !q_empty;
    ptr_next   = ptr;
    issue_next = issue;
    rdv_next   = 1'b0;
    mem_we     = 1'b0;
    mem_be     = '0;
    mem_waddr  = ptr;
    mem_wdata  = {WORD_BYTES{cur.value}};
    finish     = 1'b0;
    res_found  = 1'b0;
    res_pos    = '0;
    if (state == ENG_IDLE) begin
      if (q_pop) begin
        ptr_next   = q_head.waddr;
        issue_next = 1'b1;
      end
    end else begin
      unique case (cur.op) inside
        OP_NONE: begin
          finish = 1'b1;
        end
        OP_WRITE: begin
          mem_we    = 1'b1;
          mem_waddr = cur.waddr;
          mem_be    = WORD_BYTES'(1) << cur.lane;
          finish    = 1'b1;
        end
        OP_FILL: begin
          mem_we = 1'b1;
          mem_be = '1;
          if (ptr == cur.wend) finish = 1'b1;
          else ptr_next = ptr + WADDR_W'(1);
        end
        OP_COMP, OP_FIRST, OP_LAST: begin
          // read side: one word per cycle
          if (issue) begin
            rdv_next = 1'b1;
            if (ptr == cur.wend) issue_next = 1'b0;
            else if (cur.op == OP_LAST) ptr_next = ptr - WADDR_W'(1);
            else ptr_next = ptr + WADDR_W'(1);
          end
          // data side: word read last cycle
          if (rd_valid) begin
            case (cur.op)
              OP_COMP: begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr;
                mem_be    = inv;
                mem_wdata = ~word_data;
                if (rd_addr == cur.wend) finish = 1'b1;
              end
              OP_FIRST: begin
                if (|cand) begin
                  finish    = 1'b1;
                  res_found = 1'b1;
                  res_pos   = POS_W'({rd_addr, low_idx});
                end else if (rd_addr == cur.wend) begin
                  finish = 1'b1;
                end
              end
              default: begin
                if (|cand) begin
                  finish    = 1'b1;
                  res_found = 1'b1;
                  res_pos   = POS_W'({rd_addr, high_idx});
                end else if (rd_addr == cur.wend) begin
                  finish = 1'b1;
                end
              end
            endcase
          end
          if (finish) begin
            issue_next = 1'b0;
            rdv_next   = 1'b0;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
    if (mem_we && mem_be == '0) mem_we = 1'b0;
  end

endmodule

// File: rtl/bitmap_set_bit_search_core.sv
// latency: write, undefined commands and trivial searches strobe done 3 cycles after start
// fill takes 2 + words swept cycles, 34 for a 1024-bit bitmap
// complement and searches take 3 + words read cycles, 35 at most; searches stop at the first hit
// queued jobs follow one engine cycle apart: write 2, fill 33, complement and search words + 2
// busy rises while the two-entry job queue is full; results cannot be held off
// synchronous reset clears the bitmap (per-byte valid flags) and sets the length to 1024
module bitmap_set_bit_search_core import bsb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [INDEX_W-1:0] byte_index,
  input  logic [BYTE_W-1:0]  byte_value,
  input  logic [POS_W-1:0]   start_bit,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_data,
  output logic               done,
  output logic               found,
  output logic [POS_W-1:0]   bit_position
);

  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  task_t entry_in;
  task_t entry_out;

  assign busy = q_full;

  // front: length register and command decode
  bsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .full       (q_full),
    .command    (command),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .start_bit  (start_bit),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .entry      (entry_in)
  );

  // job queue
  bsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (entry_in),
    .pop       (pop),
    .entry_out (entry_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: bitmap store and word scanner
  bsb_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (entry_out),
    .q_pop        (pop),
    .done         (done),
    .found        (found),
    .bit_position (bit_position)
  );

endmodule
